>>> design/bhd_pkg.sv
// ----------------------------------------------------------------------------
// bhd_pkg: shared types and constants of the biharmonic distance accumulator
// Term counting limits, datapath widths, sequencer states and the request
// bundle that drives the shared divide / square-root unit.
// ----------------------------------------------------------------------------
package bhd_pkg;

  // Term counting
  localparam int MAX_TERMS = 1024;
  localparam int TIDX_W    = $clog2(MAX_TERMS + 1);
  localparam int LIMIT_W   = 11;
  localparam int CMP_W     = (TIDX_W > LIMIT_W) ? TIDX_W : LIMIT_W;

  // Datapath widths
  localparam int PHI_W  = 16;
  localparam int EV_W   = 32;
  localparam int Q_W    = 32;
  localparam int ACC_W  = 64;
  localparam int DIST_W = 32;

  // Shared unit: restoring divide (33 quotient bits) and square root (32 root bits)
  localparam int DIV_STEPS  = 33;
  localparam int SQRT_STEPS = 32;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int REM_W      = 35;
  localparam int RES_W      = 33;

  // Register map (word index)
  localparam logic REG_TERM_LIMIT = 1'b0;
  localparam int   PADDR_W        = 3;
  localparam int   PDATA_W        = 32;

  typedef enum logic {
    U_DIV,
    U_SQRT
  } unit_mode_t;

  typedef struct packed {
    logic             start;
    unit_mode_t       mode;
    logic [ACC_W-1:0] operand;
    logic [EV_W-1:0]  divisor;
  } unit_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_ACC,
    S_SQRT,
    S_PUT
  } seq_state_t;

endpackage

>>> design/bhd_in_if.sv
// ----------------------------------------------------------------------------
// bhd_in_if: eigen term channel
// Valid/ready channel carrying one eigen term per transfer.
// ----------------------------------------------------------------------------
interface bhd_in_if;
  import bhd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PHI_W-1:0] phi_source;
  logic signed [PHI_W-1:0] phi_target;
  logic [EV_W-1:0]         eigenvalue;
  logic                    last_term;

  modport source (output valid, phi_source, phi_target, eigenvalue, last_term,
                  input ready);
  modport sink   (input valid, phi_source, phi_target, eigenvalue, last_term,
                  output ready);
endinterface

>>> design/bhd_out_if.sv
// ----------------------------------------------------------------------------
// bhd_out_if: distance result channel
// Valid/ready channel carrying one distance per completed run.
// ----------------------------------------------------------------------------
interface bhd_out_if;
  import bhd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

>>> design/bhd_cfg.sv
// ----------------------------------------------------------------------------
// bhd_cfg: configuration register block
// APB-style slave holding the term limit; pready is tied high.
// ----------------------------------------------------------------------------
module bhd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bhd_pkg::PADDR_W-1:0]  paddr,
  input  logic [bhd_pkg::PDATA_W-1:0]  pwdata,
  output logic [bhd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [bhd_pkg::LIMIT_W-1:0]  term_limit
);
  import bhd_pkg::*;

  logic [LIMIT_W-1:0] term_limit_r;
  logic               wr_en;
  logic               sel_limit;

  assign sel_limit = (paddr[2] == REG_TERM_LIMIT);
  assign wr_en     = psel && penable && pwrite && sel_limit;

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_limit_r <= '0;
    end else if (wr_en) begin
      term_limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (sel_limit) begin
      prdata = {{(PDATA_W-LIMIT_W){1'b0}}, term_limit_r};
    end
  end

  assign pready     = 1'b1;
  assign term_limit = term_limit_r;

endmodule

>>> design/bhd_iter_unit.sv
// ----------------------------------------------------------------------------
// bhd_iter_unit: shared shift/subtract unit
// One restoring step per cycle: radix-2 division (33 steps) or bitwise
// integer square root (32 steps) over one shared 36-bit subtractor.
// ----------------------------------------------------------------------------
module bhd_iter_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bhd_pkg::unit_req_t        req,
  output logic                      done,
  output logic [bhd_pkg::RES_W-1:0] result
);
  import bhd_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  unit_mode_t        mode_r;
  logic [ACC_W-1:0]  src_r;
  logic [REM_W-1:0]  rem_r;
  logic [RES_W-1:0]  res_r;
  logic [EV_W-1:0]   dvs_r;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              fits;
  logic [ACC_W-1:0]  src_nxt;

  // Step datapath: bring in next operand bits, trial subtract
  always_comb begin
    unique case (mode_r)
      U_DIV: begin
        shifted = {rem_r[REM_W-2:0], src_r[ACC_W-1]};
        trial   = {{(REM_W-EV_W){1'b0}}, dvs_r};
        src_nxt = {src_r[ACC_W-2:0], 1'b0};
      end
      U_SQRT: begin
        shifted = {rem_r[REM_W-3:0], src_r[ACC_W-1:ACC_W-2]};
        trial   = {res_r[REM_W-3:0], 2'b01};
        src_nxt = {src_r[ACC_W-3:0], 2'b00};
      end
      default: begin
        shifted = rem_r;
        trial   = '0;
        src_nxt = src_r;
      end
    endcase
    diff = {1'b0, shifted} - {1'b0, trial};
    fits = !diff[REM_W];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.mode == U_DIV) ? STEP_W'(DIV_STEPS) : STEP_W'(SQRT_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      src_r  <= req.operand;
      dvs_r  <= req.divisor;
      rem_r  <= '0;
      res_r  <= '0;
    end else if (busy_r) begin
      src_r <= src_nxt;
      rem_r <= fits ? diff[REM_W-1:0] : shifted;
      res_r <= {res_r[RES_W-2:0], fits};
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> design/biharmonic_distance_accumulator.sv
// ----------------------------------------------------------------------------
// biharmonic_distance_accumulator: fixed-point biharmonic distance
// Accumulates squared eigen quotients of a run and returns their square root.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one eigen term per transfer (Q1.15 entries, Q16.16
//          eigenvalue, last_term closing the run). Term 0 and terms at or past
//          term_limit (0 = all) or MAX_TERMS add nothing.
//   out_ch carries one result per run: Q16.16 distance and a saturation flag.
//   The APB-style port holds term_limit at byte address 0.
// Timing:
//   A used term runs from one accept to the next through the accept,
//   33 radix-2 divide steps in the shared shift/subtract unit, the
//   hand-back of the quotient, the 32x32 square and the add.
//   A used term with a zero eigenvalue skips the divide; a skipped term that
//   does not close the run leaves the sequencer idle. After the last term the
//   same unit runs 32 square-root steps, then the result is loaded for out_ch;
//   in_ch.ready stays low until the sequencer is idle again.
// Reset: synchronous, active low; clears the run state and term_limit.
// Stall: a result waiting on out_ch does not block the next run; only a
//   second finished result waits for the output register to free up.
// ----------------------------------------------------------------------------
module biharmonic_distance_accumulator (
  input  logic                         clk,
  input  logic                         rst_n,
  bhd_in_if.sink                       in_ch,
  bhd_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bhd_pkg::PADDR_W-1:0]  paddr,
  input  logic [bhd_pkg::PDATA_W-1:0]  pwdata,
  output logic [bhd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import bhd_pkg::*;

  seq_state_t         state_r, state_nxt;
  logic [TIDX_W-1:0]  tidx_r, tidx_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               last_r;
  logic [Q_W-1:0]     q_r;
  logic [ACC_W-1:0]   sq_r;
  logic               sat_hold_r;
  logic [DIST_W-1:0]  dist_r;
  logic               sat_r;

  logic [LIMIT_W-1:0] term_limit;
  unit_req_t          req;
  logic               unit_done;
  logic [RES_W-1:0]   unit_res;

  logic               accept;
  logic               used;
  logic               ev_zero;
  logic               in_ready;
  logic               start_div;
  logic               start_sqrt;
  logic               load_out;
  logic signed [PHI_W:0] d_c;
  logic [PHI_W:0]     mag_c;
  logic [ACC_W:0]     sum_c;
  logic               sum_ovf;
  logic [ACC_W-1:0]   sum_sat;

  bhd_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .term_limit (term_limit)
  );

  bhd_iter_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .done   (unit_done),
    .result (unit_res)
  );

  // Term qualification and difference magnitude
  assign accept  = in_ch.valid && in_ready;
  assign ev_zero = (in_ch.eigenvalue == '0);
  assign used    = (tidx_r != '0) && (CMP_W'(tidx_r) < CMP_W'(MAX_TERMS)) &&
                   ((term_limit == '0) || (CMP_W'(tidx_r) < CMP_W'(term_limit)));
  assign d_c     = {in_ch.phi_source[PHI_W-1], in_ch.phi_source} -
                   {in_ch.phi_target[PHI_W-1], in_ch.phi_target};
  assign mag_c   = d_c[PHI_W] ? (PHI_W+1)'(-d_c) : d_c;

  // Saturating accumulate
  assign sum_c   = {1'b0, acc_r} + {1'b0, sq_r};
  assign sum_ovf = sum_c[ACC_W];
  assign sum_sat = sum_ovf ? '1 : sum_c[ACC_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (used && !ev_zero) begin
            state_nxt = S_DIV;
          end else if (used) begin
            state_nxt = S_MUL;
          end else if (in_ch.last_term) begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_DIV:  if (unit_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = last_r ? S_SQRT : S_IDLE;
      S_SQRT: if (unit_done) state_nxt = S_PUT;
      S_PUT:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = 1'b0;
    start_div  = 1'b0;
    start_sqrt = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        start_div  = accept && used && !ev_zero;
        start_sqrt = accept && !used && in_ch.last_term;
      end
      S_ACC:  start_sqrt = last_r;
      S_PUT:  load_out   = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Shared unit request: divide |d|*2^17 by the eigenvalue, or root of the sum.
  // The 33-bit dividend sits at the top of the shift register, where the
  // 33 divide steps pick it up MSB first.
  always_comb begin
    req.start   = start_div || start_sqrt;
    req.mode    = start_div ? U_DIV : U_SQRT;
    req.divisor = in_ch.eigenvalue;
    if (start_div) begin
      req.operand = {mag_c[PHI_W-1:0], {(ACC_W-PHI_W){1'b0}}};
    end else if (state_r == S_ACC) begin
      req.operand = sum_sat;
    end else begin
      req.operand = acc_r;
    end
  end

  // Run state next values
  always_comb begin
    tidx_nxt = tidx_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    if (accept && (CMP_W'(tidx_r) < CMP_W'(MAX_TERMS))) begin
      tidx_nxt = tidx_r + TIDX_W'(1);
    end
    if (accept && used && ev_zero) begin
      ovf_nxt = 1'b1;
    end
    if (state_r == S_DIV && unit_done && unit_res[RES_W-1]) begin
      ovf_nxt = 1'b1;
    end
    if (state_r == S_ACC) begin
      acc_nxt = sum_sat;
      ovf_nxt = ovf_r || sum_ovf;
    end
    if (start_sqrt) begin
      tidx_nxt = '0;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tidx_r      <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tidx_r      <= tidx_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_ch.last_term;
      if (used && ev_zero) begin
        q_r <= '1;
      end
    end
    if (state_r == S_DIV && unit_done) begin
      q_r <= unit_res[RES_W-1] ? '1 : unit_res[Q_W-1:0];
    end
    if (state_r == S_MUL) begin
      sq_r <= q_r * q_r;
    end
    if (start_sqrt) begin
      sat_hold_r <= (state_r == S_ACC) ? (ovf_r || sum_ovf) : ovf_r;
    end
    if (load_out) begin
      dist_r <= unit_res[DIST_W-1:0];
      sat_r  <= sat_hold_r;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = dist_r;
  assign out_ch.saturated = sat_r;

endmodule

>>> test/tb_biharmonic_distance_accumulator.sv
// ----------------------------------------------------------------------------
// tb_biharmonic_distance_accumulator: self-checking block testbench
// Streams eigen term runs into the accumulator under several term limits,
// predicts each run's Q16.16 distance and saturation flag in fixed point, and
// compares every distance transfer against the oldest prediction. Both
// channels idle and stall at random; long receiver hold-offs back the
// block up into its input.
// ----------------------------------------------------------------------------
module tb_biharmonic_distance_accumulator;
  import bhd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 750_000;

  // term_limit lives at word index REG_TERM_LIMIT, byte address = 4 * index
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_TERM_LIMIT, 2'b00};

  typedef struct packed {
    logic signed [PHI_W-1:0] phi_source;
    logic signed [PHI_W-1:0] phi_target;
    logic [EV_W-1:0]         eigenvalue;
    logic                    last_term;
  } eigen_term_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } dist_result_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  bhd_in_if  term_ch ();
  bhd_out_if dist_ch ();

  biharmonic_distance_accumulator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (term_ch),
    .out_ch  (dist_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pending stimulus and predicted distances
  eigen_term_t  term_q[$];
  dist_result_t dist_expect_q[$];

  int terms_pushed;
  int terms_taken;
  int mismatch_count;
  int src_gap_max;
  int snk_stall_max;
  int src_gap;
  int snk_wait;
  int hold_left;
  int holds_asked;
  int holds_served;

  // Shadow of the run state and the limit register
  int unsigned         run_index;
  logic [ACC_W-1:0]    run_sum;
  logic                run_sat;
  logic [LIMIT_W-1:0]  limit_shadow;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Floor square root by bitwise trial, MSB first
  function automatic logic [DIST_W-1:0] root_floor(input logic [ACC_W-1:0] v);
    logic [DIST_W-1:0] r;
    logic [DIST_W-1:0] trial;
    r = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = r | (DIST_W'(1) << b);
      if ({32'b0, trial} * {32'b0, trial} <= v) r = trial;
    end
    return r;
  endfunction

  // Fold one accepted term into the shadow run; a closing term yields a distance
  function automatic void accumulate_term(input eigen_term_t t);
    logic signed [PHI_W:0] diff;
    logic [PHI_W:0]        mag;
    logic [ACC_W-1:0]      quo;
    logic [ACC_W-1:0]      sq;
    logic [ACC_W:0]        wide_sum;
    logic                  counted;
    dist_result_t          res;
    counted = (run_index != 0) && (run_index < MAX_TERMS) &&
              (limit_shadow == 0 || run_index < limit_shadow);
    if (counted) begin
      diff = {t.phi_source[PHI_W-1], t.phi_source} - {t.phi_target[PHI_W-1], t.phi_target};
      mag  = diff[PHI_W] ? -diff : diff;
      if (t.eigenvalue == '0) begin
        quo     = 64'hFFFF_FFFF;
        run_sat = 1'b1;
      end else begin
        quo = ({47'b0, mag} << 17) / {32'b0, t.eigenvalue};
        if (quo[63:32] != '0) begin
          quo     = 64'hFFFF_FFFF;
          run_sat = 1'b1;
        end
      end
      sq       = quo * quo;
      wide_sum = {1'b0, run_sum} + {1'b0, sq};
      if (wide_sum[ACC_W]) begin
        run_sum = '1;
        run_sat = 1'b1;
      end else begin
        run_sum = wide_sum[ACC_W-1:0];
      end
    end
    if (run_index < MAX_TERMS) run_index++;
    if (t.last_term) begin
      res.distance  = root_floor(run_sum);
      res.saturated = run_sat;
      dist_expect_q.push_back(res);
      run_index = 0;
      run_sum   = '0;
      run_sat   = 1'b0;
    end
  endfunction

  function automatic logic signed [PHI_W-1:0] pick_phi();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly full-range random eigenvalues; moderate ones often; zero, all-ones and tiny ones now and then
  function automatic logic [EV_W-1:0] pick_eigen();
    case ($urandom_range(0, 31))
      0: return '0;
      1: return '1;
      2, 3, 4: return $urandom_range(1, 32'h0000_FFFF);
      5, 6, 7, 8, 9, 10, 11, 12, 13, 14: return $urandom_range(32'h1_0000, 32'hFF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_term(input logic signed [PHI_W-1:0] ps,
                                    input logic signed [PHI_W-1:0] pt,
                                    input logic [EV_W-1:0] ev, input logic last);
    eigen_term_t t;
    t.phi_source = ps;
    t.phi_target = pt;
    t.eigenvalue = ev;
    t.last_term  = last;
    term_q.push_back(t);
    terms_pushed++;
  endfunction

  function automatic void queue_run(input int len);
    for (int i = 0; i < len; i++)
      push_term(pick_phi(), pick_phi(), pick_eigen(), i == len - 1);
  endfunction

  // Term channel driver: one item per transfer, random gap after each
  always @(posedge clk) begin
    eigen_term_t nxt;
    if (!rst_n) begin
      term_ch.valid <= 1'b0;
      src_gap <= 0;
    end else if (!term_ch.valid || term_ch.ready) begin
      if (src_gap != 0) begin
        term_ch.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (term_q.size() != 0) begin
        nxt = term_q.pop_front();
        term_ch.phi_source <= nxt.phi_source;
        term_ch.phi_target <= nxt.phi_target;
        term_ch.eigenvalue <= nxt.eigenvalue;
        term_ch.last_term  <= nxt.last_term;
        term_ch.valid      <= 1'b1;
        src_gap <= $urandom_range(0, src_gap_max);
      end else begin
        term_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // Distance channel receiver: random stall after each transfer
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      dist_ch.ready <= 1'b0;
      snk_wait <= 0;
    end else if (hold_left != 0) begin
      dist_ch.ready <= 1'b0;
    end else if (dist_ch.valid && dist_ch.ready) begin
      w = $urandom_range(0, snk_stall_max);
      snk_wait <= w;
      dist_ch.ready <= (w == 0);
    end else if (snk_wait != 0) begin
      snk_wait <= snk_wait - 1;
      dist_ch.ready <= (snk_wait == 1);
    end else begin
      dist_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on term transfers, check on distance transfers
  always @(posedge clk) begin
    eigen_term_t  seen;
    dist_result_t want;
    if (rst_n) begin
      if (term_ch.valid && term_ch.ready) begin
        seen.phi_source = term_ch.phi_source;
        seen.phi_target = term_ch.phi_target;
        seen.eigenvalue = term_ch.eigenvalue;
        seen.last_term  = term_ch.last_term;
        accumulate_term(seen);
        terms_taken++;
      end
      if (dist_ch.valid && dist_ch.ready) begin
        if (dist_expect_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual distance %h saturated %b",
                   $time, dist_ch.distance, dist_ch.saturated);
          mismatch_count++;
        end else begin
          want = dist_expect_q.pop_front();
          if (dist_ch.distance !== want.distance) begin
            $display("%0t: distance: expected %h, actual %h",
                     $time, want.distance, dist_ch.distance);
            mismatch_count++;
          end
          if (dist_ch.saturated !== want.saturated) begin
            $display("%0t: saturated: expected %b, actual %b",
                     $time, want.saturated, dist_ch.saturated);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Write term_limit, then read it back over the same port
  task automatic set_term_limit(input logic [LIMIT_W-1:0] lim);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= PDATA_W'(lim);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_shadow = lim;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(lim)) begin
      $display("%0t: term_limit readback: expected %h, actual %h",
               $time, PDATA_W'(lim), prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every term is taken and every distance is back, then let it settle
  task automatic drain();
    while (terms_taken != terms_pushed || dist_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n_items,
                           input int long_len, input int src_max, input int snk_max,
                           input bit squeeze);
    int target;
    int len;
    set_term_limit(lim);
    @(negedge clk);
    src_gap_max   = src_max;
    snk_stall_max = snk_max;
    target = terms_pushed + n_items;
    while (terms_pushed < target) begin
      len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      queue_run(len);
    end
    if (long_len != 0) queue_run(long_len);
    if (squeeze) holds_asked++;
    drain();
  endtask

  // Timeout
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    term_ch.valid      = 1'b0;
    term_ch.phi_source = '0;
    term_ch.phi_target = '0;
    term_ch.eigenvalue = '0;
    term_ch.last_term  = 1'b0;
    dist_ch.ready      = 1'b0;
    terms_pushed       = 0;
    terms_taken        = 0;
    mismatch_count     = 0;
    holds_asked        = 0;
    src_gap_max        = 12;
    snk_stall_max      = 12;
    run_index          = 0;
    run_sum            = '0;
    run_sat            = 1'b0;
    limit_shadow       = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed runs with no term limit; every term past term 0 counted
    set_term_limit('0);
    @(negedge clk);
    // term 0 skipped despite zero eigenvalue; quotient overflow; zero eigenvalue
    // with equal entries; sum overflow on the closing term
    push_term(16'sh8000, 16'sh7FFF, 32'h0, 1'b0);
    push_term(16'sh7FFF, 16'sh8000, 32'h1, 1'b0);
    push_term(16'sh0000, 16'sh0000, 32'h0, 1'b0);
    push_term(16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1);
    // run of a single term: nothing counted
    push_term(16'sh0000, 16'sh0000, 32'h0, 1'b1);
    // clean run
    push_term(16'sd123, -16'sd77, 32'h0001_0000, 1'b0);
    push_term(16'sd16384, 16'sh0000, 32'h0001_0000, 1'b0);
    push_term(16'sh0000, 16'sd16384, 32'h0002_0000, 1'b0);
    push_term(16'sd1, -16'sd1, 32'hFFFF_FFFF, 1'b0);
    push_term(16'sh8000, 16'sh8000, 32'h0000_8000, 1'b1);
    // two saturated quotients whose squares overflow the sum
    push_term(16'sd5, 16'sd5, 32'h1, 1'b0);
    push_term(16'sh7FFF, 16'sh8000, 32'h1, 1'b0);
    push_term(16'sh7FFF, 16'sh8000, 32'h1, 1'b1);
    // negative difference, fractional quotient
    push_term(16'sh0000, 16'sh0000, 32'h7, 1'b0);
    push_term(-16'sd1, 16'sh0000, 32'h3, 1'b1);
    // zero eigenvalue on a nonzero difference
    push_term(16'sh0000, 16'sh0000, 32'h1, 1'b0);
    push_term(16'sd100, 16'sd50, 32'h0, 1'b1);
    drain();

    // Random runs under a range of limits
    run_phase(11'd1024, 150, 0, 12, 12, 1'b0);
    run_phase(11'd1, 60, 0, 0, 0, 1'b1);
    run_phase(11'($urandom_range(2, 12)), 120, 0, 12, 0, 1'b0);
    run_phase(11'd2, 90, 0, 0, 12, 1'b0);
    // open limits: zero, and a value past MAX_TERMS
    run_phase(11'd0, 110, 0, 12, 12, 1'b1);
    run_phase(11'd2047, 50, 0, 0, 3, 1'b0);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> biharmonic_distance_accumulator.f
design/bhd_pkg.sv
design/bhd_in_if.sv
design/bhd_out_if.sv
design/bhd_cfg.sv
design/bhd_iter_unit.sv
design/biharmonic_distance_accumulator.sv
test/tb_biharmonic_distance_accumulator.sv
